// File: src/z80ibd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// z80ibd_pkg
// Types, opcode constants and the base-page length table for the Z80
// instruction boundary decoder.
// ----------------------------------------------------------------------------
package z80ibd_pkg;

   typedef enum logic [2:0] {
      PH_START = 3'd0,
      PH_CBOP  = 3'd1,
      PH_EDOP  = 3'd2,
      PH_OPER  = 3'd3
   } phase_type;

   localparam logic [7:0] BYTE_DD      = 8'hDD;
   localparam logic [7:0] BYTE_FD      = 8'hFD;
   localparam logic [7:0] BYTE_CB      = 8'hCB;
   localparam logic [7:0] BYTE_ED      = 8'hED;
   localparam logic [7:0] BYTE_HALT    = 8'h76;
   localparam logic [7:0] ED_LDNN_MASK = 8'hC7;
   localparam logic [7:0] ED_LDNN_CODE = 8'h43;

   localparam logic [1:0] PAGE_BASE   = 2'd0;
   localparam logic [1:0] PAGE_CB     = 2'd1;
   localparam logic [1:0] PAGE_ED     = 2'd2;
   localparam logic [1:0] PAGE_PREFIX = 2'd3;

   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_IX   = 2'd1;
   localparam logic [1:0] KIND_IY   = 2'd2;

   localparam logic [3:0] POS_MAX = 4'd15;

   typedef struct packed {
      phase_type  phase;
      logic [3:0] taken;
      logic [1:0] remaining;
      logic [1:0] index;
      logic [1:0] page;
   } state_type;

   typedef struct packed {
      logic [3:0] byte_position;
      logic       instr_end;
      logic [3:0] instr_length;
      logic [1:0] opcode_page;
      logic [1:0] index_kind;
   } result_type;

   // length of a base-page instruction counted from its opcode byte
   function automatic logic [1:0] base_length(input logic [7:0] op, input logic ix);
      logic [1:0] x;
      logic [2:0] y;
      logic [2:0] z;
      logic [1:0] len;
      x   = op[7:6];
      y   = op[5:3];
      z   = op[2:0];
      len = 2'd1;
      case (x)
         2'd0: begin
            case (z)
               3'd0: len = (y < 3'd2) ? 2'd1 : 2'd2;
               3'd1: len = y[0] ? 2'd1 : 2'd3;
               3'd2: len = (y >= 3'd4) ? 2'd3 : 2'd1;
               3'd4, 3'd5: len = (y == 3'd6 && ix) ? 2'd2 : 2'd1;
               3'd6: len = (y == 3'd6 && ix) ? 2'd3 : 2'd2;
               default: len = 2'd1;
            endcase
         end
         2'd1: begin
            if (op == BYTE_HALT) begin
               len = 2'd1;
            end else begin
               len = ((y == 3'd6 || z == 3'd6) && ix) ? 2'd2 : 2'd1;
            end
         end
         2'd2: len = (z == 3'd6 && ix) ? 2'd2 : 2'd1;
         default: begin
            case (z)
               3'd2: len = 2'd3;
               3'd3: len = (y == 3'd0) ? 2'd3 :
                           ((y == 3'd2 || y == 3'd3) ? 2'd2 : 2'd1);
               3'd4: len = 2'd3;
               3'd5: len = (y == 3'd1) ? 2'd3 : 2'd1;
               3'd6: len = 2'd2;
               default: len = 2'd1;
            endcase
         end
      endcase
      return len;
   endfunction

endpackage

// File: src/z80ibd_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// z80ibd_decode
// Decodes one code byte against the held instruction state and gives the
// result word and the next state.
// ----------------------------------------------------------------------------
module z80ibd_decode (
   input  z80ibd_pkg::state_type  state_cur,
   input  logic [7:0]             code_byte,
   input  logic                   restart,
   output z80ibd_pkg::state_type  state_nxt,
   output z80ibd_pkg::result_type result
);

   z80ibd_pkg::state_type cleared;
   z80ibd_pkg::state_type cur;
   z80ibd_pkg::state_type nst;
   logic [3:0]            pos;
   logic [3:0]            nxt_pos;
   logic                  end_flag;
   logic [1:0]            blen;

   always_comb begin
      cleared.phase     = z80ibd_pkg::PH_START;
      cleared.taken     = 4'd0;
      cleared.remaining = 2'd0;
      cleared.index     = z80ibd_pkg::KIND_NONE;
      cleared.page      = z80ibd_pkg::PAGE_BASE;

      cur      = restart ? cleared : state_cur;
      pos      = cur.taken;
      nxt_pos  = (pos != z80ibd_pkg::POS_MAX) ? pos + 4'd1 : z80ibd_pkg::POS_MAX;
      nst      = cur;
      end_flag = 1'b0;
      blen     = z80ibd_pkg::base_length(code_byte, cur.index != z80ibd_pkg::KIND_NONE);

      case (cur.phase)
         z80ibd_pkg::PH_OPER: begin
            if (cur.remaining <= 2'd1) begin
               nst.remaining = 2'd0;
               end_flag      = 1'b1;
            end else begin
               nst.remaining = cur.remaining - 2'd1;
            end
         end
         z80ibd_pkg::PH_CBOP: begin
            end_flag = 1'b1;
         end
         z80ibd_pkg::PH_EDOP: begin
            if ((code_byte & z80ibd_pkg::ED_LDNN_MASK) == z80ibd_pkg::ED_LDNN_CODE) begin
               nst.remaining = 2'd2;
               nst.phase     = z80ibd_pkg::PH_OPER;
            end else begin
               end_flag = 1'b1;
            end
         end
         default: begin
            // unused phase codes behave as the start phase
            if (code_byte == z80ibd_pkg::BYTE_DD || code_byte == z80ibd_pkg::BYTE_FD) begin
               nst.index = (code_byte == z80ibd_pkg::BYTE_DD) ? z80ibd_pkg::KIND_IX :
                                                                z80ibd_pkg::KIND_IY;
               nst.page  = z80ibd_pkg::PAGE_PREFIX;
               nst.phase = z80ibd_pkg::PH_START;
            end else if (code_byte == z80ibd_pkg::BYTE_CB) begin
               nst.page = z80ibd_pkg::PAGE_CB;
               // indexed cb: displacement and opcode follow
               if (cur.index != z80ibd_pkg::KIND_NONE) begin
                  nst.remaining = 2'd2;
                  nst.phase     = z80ibd_pkg::PH_OPER;
               end else begin
                  nst.phase = z80ibd_pkg::PH_CBOP;
               end
            end else if (code_byte == z80ibd_pkg::BYTE_ED) begin
               nst.page  = z80ibd_pkg::PAGE_ED;
               nst.phase = z80ibd_pkg::PH_EDOP;
            end else begin
               nst.page = z80ibd_pkg::PAGE_BASE;
               if (blen <= 2'd1) begin
                  end_flag = 1'b1;
               end else begin
                  nst.remaining = blen - 2'd1;
                  nst.phase     = z80ibd_pkg::PH_OPER;
               end
            end
         end
      endcase

      result.byte_position = pos;
      result.instr_end     = end_flag;
      result.instr_length  = end_flag ? nxt_pos : 4'd0;
      result.opcode_page   = nst.page;
      result.index_kind    = nst.index;

      if (end_flag) begin
         state_nxt = cleared;
      end else begin
         state_nxt       = nst;
         state_nxt.taken = nxt_pos;
      end
   end

endmodule

// File: src/z80_instruction_boundary_decoder.sv
`timescale 1ns / 1ps
// an accepted word lands in the input register, then is decoded into the result register for the rsp side
// throughput: one word per cycle, sustained while the rsp side does not stall
// the decode state advances as a word leaves the input register for the result register
// reset clears the decode state and both valid flags; payload registers are not reset
// ----------------------------------------------------------------------------
// z80_instruction_boundary_decoder
// Marks Z80 instruction boundaries in a stream of code bytes, one result
// word per byte.
// ----------------------------------------------------------------------------
module z80_instruction_boundary_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_code_byte,
   input  logic       req_restart,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [3:0] rsp_byte_position,
   output logic       rsp_instr_end,
   output logic [3:0] rsp_instr_length,
   output logic [1:0] rsp_opcode_page,
   output logic [1:0] rsp_index_kind
);

   logic                   s1_valid_ff;
   logic                   s1_valid_in;
   logic [7:0]             s1_byte_ff;
   logic                   s1_restart_ff;
   z80ibd_pkg::state_type  state_ff;
   z80ibd_pkg::state_type  state_in;
   z80ibd_pkg::result_type result;
   z80ibd_pkg::result_type rsp_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic                   out_free;
   logic                   advance;
   logic                   req_take;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign s1_valid_in  = req_take || (s1_valid_ff && !out_free);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   z80ibd_decode u_decode (
      .state_cur (state_ff),
      .code_byte (s1_byte_ff),
      .restart   (s1_restart_ff),
      .state_nxt (state_in),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff        <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         state_ff.phase     <= z80ibd_pkg::PH_START;
         state_ff.taken     <= 4'd0;
         state_ff.remaining <= 2'd0;
         state_ff.index     <= z80ibd_pkg::KIND_NONE;
         state_ff.page      <= z80ibd_pkg::PAGE_BASE;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff    <= req_code_byte;
         s1_restart_ff <= req_restart;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_byte_position = rsp_ff.byte_position;
   assign rsp_instr_end     = rsp_ff.instr_end;
   assign rsp_instr_length  = rsp_ff.instr_length;
   assign rsp_opcode_page   = rsp_ff.opcode_page;
   assign rsp_index_kind    = rsp_ff.index_kind;

endmodule

// File: src/z80ibd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// z80ibd_checker
// Port-level checks for the Z80 instruction boundary decoder.
// ----------------------------------------------------------------------------
module z80ibd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [3:0] rsp_byte_position,
   input logic       rsp_instr_end,
   input logic [3:0] rsp_instr_length,
   input logic [1:0] rsp_opcode_page,
   input logic [1:0] rsp_index_kind
);

   // a stalled word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_byte_position) &&
         $stable(rsp_instr_end) && $stable(rsp_instr_length) &&
         $stable(rsp_opcode_page) && $stable(rsp_index_kind))
      else $error("stalled rsp word changed");

   // length only on the last byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_instr_end |-> rsp_instr_length == 4'd0)
      else $error("length given on a non-final byte");

   // length is position plus one, saturating
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_instr_end |->
         (rsp_byte_position != z80ibd_pkg::POS_MAX &&
          rsp_instr_length == rsp_byte_position + 4'd1) ||
         (rsp_byte_position == z80ibd_pkg::POS_MAX &&
          rsp_instr_length == z80ibd_pkg::POS_MAX))
      else $error("length does not match position");

   // a prefix byte never ends an instruction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_opcode_page == z80ibd_pkg::PAGE_PREFIX |->
         !rsp_instr_end && rsp_index_kind != z80ibd_pkg::KIND_NONE)
      else $error("prefix word ends instruction or lacks index");

   // with an empty pipe nothing can come out next cycle
   assert property (@(posedge clock) disable iff (reset)
      !req_stall && !rsp_valid && !$past(req_valid) |=> !rsp_valid)
      else $error("rsp word without a request");

endmodule

bind z80_instruction_boundary_decoder z80ibd_checker u_z80ibd_checker (.*);
